>>> hdl/rv32_subset_core_top_assert.svh
// Assertion macros used by the checker file.
`ifndef RV32_SUBSET_CORE_TOP_ASSERT_SVH
`define RV32_SUBSET_CORE_TOP_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is asserted.
`define RVS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define RVS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rvs_pkg.sv
`timescale 1ns / 1ps
package rvs_pkg;

	localparam logic [6:0] OP_R      = 7'h33;
	localparam logic [6:0] OP_I      = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_HALT   = 7'h00;

	localparam logic [2:0] F3_ADD  = 3'h0;
	localparam logic [2:0] F3_XOR  = 3'h4;
	localparam logic [2:0] F3_SRA  = 3'h5;
	localparam logic [2:0] F3_AND  = 3'h7;
	localparam logic [2:0] F3_WORD = 3'h2;

	localparam logic [6:0] F7_ADD = 7'h00;
	localparam logic [6:0] F7_SUB = 7'h20;

	localparam logic [1:0] ST_EXEC    = 2'd0;
	localparam logic [1:0] ST_HALT    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        load;
		logic        store;
		logic [31:0] addr;
		logic        count;
		logic        rtype;
	} rvs_exec_t;

endpackage

>>> hdl/rvs_regfile.sv
`timescale 1ns / 1ps
module rvs_regfile
	import rvs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [4:0]  raddr_a,
	input  logic [4:0]  raddr_b,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);

	logic [31:0] mem [32];
	logic [31:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first registered reads, unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (we && waddr == raddr_a) begin
			rdata_a <= wdata;
		end else begin
			rdata_a <= valid_q[raddr_a] ? mem[raddr_a] : '0;
		end
		if (we && waddr == raddr_b) begin
			rdata_b <= wdata;
		end else begin
			rdata_b <= valid_q[raddr_b] ? mem[raddr_b] : '0;
		end
	end

endmodule

>>> hdl/rvs_dmem.sv
`timescale 1ns / 1ps
module rvs_dmem
	import rvs_pkg::*;
#(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic          wr_en,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata,
	output logic          busy
);

	logic [31:0]   mem [DEPTH];
	logic [AW-1:0] clr_idx_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

	assign busy = busy_q;

endmodule

>>> hdl/rvs_exec.sv
`timescale 1ns / 1ps
module rvs_exec
	import rvs_pkg::*;
(
	input  logic [31:0] instr,
	input  logic [31:0] pc,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output rvs_exec_t   res
);

	logic [6:0]  opcode;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] immi;
	logic [31:0] imms;
	logic [31:0] immb;
	logic [31:0] pc4;
	logic        wr;
	logic [31:0] val;

	assign opcode = instr[6:0];
	assign f3     = instr[14:12];
	assign f7     = instr[31:25];
	assign rd     = instr[11:7];
	assign immi   = {{20{instr[31]}}, instr[31:20]};
	assign imms   = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign immb   = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign pc4    = pc + 32'd4;

	always_comb begin
		res.status = ST_EXEC;
		res.npc    = pc4;
		res.load   = 1'b0;
		res.store  = 1'b0;
		res.addr   = a + immi;
		res.count  = 1'b1;
		res.rtype  = 1'b0;
		wr         = 1'b0;
		val        = '0;
		case (opcode)
			OP_R: begin
				if (f3 == F3_ADD && f7 == F7_ADD) begin
					val = a + b;
				end else if (f3 == F3_ADD && f7 == F7_SUB) begin
					val = a - b;
				end else if (f3 == F3_XOR) begin
					val = a ^ b;
				end else if (f3 == F3_SRA) begin
					val = $unsigned($signed(a) >>> b[4:0]);
				end
				if ((f3 == F3_ADD && (f7 == F7_ADD || f7 == F7_SUB)) || f3 inside {F3_XOR, F3_SRA}) begin
					wr        = 1'b1;
					res.rtype = 1'b1;
				end else begin
					res.status = ST_ILLEGAL;
					res.count  = 1'b0;
				end
			end
			OP_I: begin
				if (f3 inside {F3_ADD, F3_AND}) begin
					wr  = 1'b1;
					val = (f3 == F3_ADD) ? a + immi : a & immi;
				end else begin
					res.status = ST_ILLEGAL;
					res.count  = 1'b0;
				end
			end
			OP_LOAD: begin
				if (f3 == F3_WORD) begin
					wr       = 1'b1;
					res.load = 1'b1;
				end else begin
					res.status = ST_ILLEGAL;
					res.count  = 1'b0;
				end
			end
			OP_STORE: begin
				res.addr = a + imms;
				if (f3 == F3_WORD) begin
					res.store = 1'b1;
				end else begin
					res.status = ST_ILLEGAL;
					res.count  = 1'b0;
				end
			end
			OP_BRANCH: begin
				if ($signed(a) < $signed(b)) begin
					res.npc = pc + immb;
				end
			end
			OP_JALR: begin
				res.npc = a + immi;
				wr      = 1'b1;
				val     = pc4;
			end
			OP_HALT: begin
				res.status = ST_HALT;
				res.count  = 1'b0;
			end
			default: begin
				res.status = ST_ILLEGAL;
				res.count  = 1'b0;
			end
		endcase
		res.wr  = wr && rd != 5'd0;
		res.rd  = res.wr ? rd : 5'd0;
		res.val = res.wr ? val : '0;
	end

endmodule

>>> hdl/rv32_subset_core_top.sv
`timescale 1ns / 1ps
// RV32 subset core: one instruction per transfer, one result per instruction, in order. A new
// instruction is taken every cycle when results are taken every cycle; a taken instruction sits
// in the instruction register for the execute stage, then its result sits in the result register,
// where the data store's registered read lands for loads. After reset the data store is swept to
// zero, one word per cycle, and in_stall stays high until the sweep is done. DMEM_DEPTH must be
// a power of two; the effective address is masked to it as a word index.
module rv32_subset_core_top
	import rvs_pkg::*;
#(
	parameter int DMEM_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] next_pc,
	output logic        reg_write_enable,
	output logic [4:0]  reg_write_index,
	output logic [31:0] reg_write_value,
	output logic [31:0] instr_count,
	output logic [31:0] rtype_count
);

	localparam int AW = $clog2(DMEM_DEPTH);

	logic        accept;
	logic        adv;
	logic        take;
	logic        busy;

	logic        valid_s1;
	logic [31:0] instr_s1;

	logic        valid_s2;
	logic [1:0]  status_s2;
	logic [31:0] npc_s2;
	logic        wr_s2;
	logic [4:0]  rd_s2;
	logic [31:0] val_s2;
	logic        load_s2;
	logic [31:0] icnt_s2;
	logic [31:0] rcnt_s2;

	logic [31:0] pc_q;
	logic [31:0] icnt_q;
	logic [31:0] rcnt_q;
	logic [31:0] icnt_next;
	logic [31:0] rcnt_next;

	logic [4:0]  raddr_a;
	logic [4:0]  raddr_b;
	logic [31:0] rf_a;
	logic [31:0] rf_b;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] wval;
	logic [31:0] dm_rdata;
	rvs_exec_t   ex;

	assign take     = valid_s2 && !out_stall;
	assign adv      = valid_s1 && (!valid_s2 || take);
	assign in_stall = busy || (valid_s1 && !adv);
	assign accept   = in_valid && !in_stall;

	assign raddr_a = accept ? instr_word[19:15] : instr_s1[19:15];
	assign raddr_b = accept ? instr_word[24:20] : instr_s1[24:20];

	assign wval = load_s2 ? dm_rdata : val_s2;

	// forward the result still waiting in the output register
	assign op_a = (valid_s2 && wr_s2 && rd_s2 == instr_s1[19:15]) ? wval : rf_a;
	assign op_b = (valid_s2 && wr_s2 && rd_s2 == instr_s1[24:20]) ? wval : rf_b;

	rvs_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (take && wr_s2),
		.waddr   (rd_s2),
		.wdata   (wval),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	rvs_exec u_exec (
		.instr (instr_s1),
		.pc    (pc_q),
		.a     (op_a),
		.b     (op_b),
		.res   (ex)
	);

	rvs_dmem #(
		.DEPTH (DMEM_DEPTH)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (adv && ex.load),
		.wr_en  (adv && ex.store),
		.addr   (ex.addr[AW-1:0]),
		.wdata  (op_b),
		.rdata  (dm_rdata),
		.busy   (busy)
	);

	assign icnt_next = icnt_q + {31'd0, ex.count};
	assign rcnt_next = rcnt_q + {31'd0, ex.rtype};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pc_q     <= '0;
			icnt_q   <= '0;
			rcnt_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				pc_q     <= ex.npc;
				icnt_q   <= icnt_next;
				rcnt_q   <= rcnt_next;
			end else if (take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr_word;
		end
		if (adv) begin
			status_s2 <= ex.status;
			npc_s2    <= ex.npc;
			wr_s2     <= ex.wr;
			rd_s2     <= ex.rd;
			val_s2    <= ex.val;
			load_s2   <= ex.load && ex.wr;
			icnt_s2   <= icnt_next;
			rcnt_s2   <= rcnt_next;
		end
	end

	assign out_valid        = valid_s2;
	assign status           = status_s2;
	assign next_pc          = npc_s2;
	assign reg_write_enable = wr_s2;
	assign reg_write_index  = rd_s2;
	assign reg_write_value  = wval;
	assign instr_count      = icnt_s2;
	assign rtype_count      = rcnt_s2;

endmodule

>>> hdl/rvs_checker.sv
`timescale 1ns / 1ps
`include "rv32_subset_core_top_assert.svh"
module rvs_checker
	import rvs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        reg_write_enable,
	input logic [4:0]  reg_write_index,
	input logic [31:0] reg_write_value
);

	`RVS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`RVS_ASSERT(a_fault_no_write, out_valid && status != ST_EXEC |-> !reg_write_enable, "fault wrote")
	`RVS_ASSERT(a_no_write_zero, out_valid && !reg_write_enable |-> reg_write_index == 5'd0 && reg_write_value == 32'd0, "write fields not cleared")
	`RVS_ASSERT(a_no_x0, out_valid && reg_write_enable |-> reg_write_index != 5'd0, "write to x0 reported")
	`RVS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result shown during reset")

endmodule

bind rv32_subset_core_top rvs_checker u_rvs_checker (.*);
